/* rtl/sorted_table_insert_delete_macros.svh */
// ============================================================================
// Assertion macros for the sorted table
// Immediate-next and same-cycle implication checks, removed for synthesis.
// ============================================================================
`ifndef SORTED_TABLE_INSERT_DELETE_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define STI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed");

// The consequent must hold in the cycle after the antecedent.
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed");

`else

`define STI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/sti_pkg.sv */
// ============================================================================
// sti_pkg
// Shared types and sizes for the sorted table and its storage cells.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

    // Table size and derived widths.
    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 4;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/sti_cell.sv */
// ============================================================================
// sti_cell
// One storage cell of the sorted chain: holds one entry and shifts with its
// neighbors on insert and delete.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sti_cell (
    input  wire logic                            clk,
    input  wire sti_pkg::cell_cmd_t              cmd,
    input  wire logic                            occupied,
    input  wire logic signed [sti_pkg::VAL_W-1:0] left_entry,
    input  wire logic                            left_ge,
    input  wire logic signed [sti_pkg::VAL_W-1:0] right_entry,
    input  wire logic                            hit_in,
    input  wire logic                            read_here,
    input  wire logic        [sti_pkg::VAL_W-1:0] rd_in,
    output logic signed      [sti_pkg::VAL_W-1:0] entry,
    output logic                                 ge,
    output logic                                 hit_out,
    output logic             [sti_pkg::VAL_W-1:0] rd_out
);
    import sti_pkg::*;

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    match;

    // An empty slot counts as not smaller, so the new value lands there.
    assign ge      = !occupied || (entry_reg >= cmd.value);
    assign match   = occupied && (entry_reg == cmd.value);
    assign hit_out = hit_in || match;
    assign entry   = entry_reg;

    // Read data ripples along the chain; only the addressed cell adds its entry.
    assign rd_out = rd_in | ((read_here && occupied) ? entry_reg : '0);

    // Insert shifts right from the slot onward; delete shifts left from the match.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge)
            begin
                entry_next = cmd.value;
            end
        end
        else if (cmd.del && hit_out)
        begin
            entry_next = right_entry;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* rtl/sorted_table_insert_delete.sv */
// The result of an accepted item is registered and valid in the next cycle.
// Throughput: one item per cycle; input ready is held low only while a
// result waits in the output register and out_ready is low.
// Insert, delete and read act on all cells of the chain in the same cycle.
// Reset clears the entry count and the output valid; cell contents are not
// cleared and are ignored above the count.
// ============================================================================
// sorted_table_insert_delete
// Ascending table of signed values built as a chain of shifting cells.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_insert_delete_macros.svh"

module sorted_table_insert_delete (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic        [1:0]                 action,
    input  wire logic signed [sti_pkg::VAL_W-1:0]  value,
    input  wire logic        [sti_pkg::POS_W-1:0]  position,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic             [1:0]                 status,
    output logic signed      [sti_pkg::VAL_W-1:0]  read_value,
    output logic             [4:0]                 entry_count
);
    import sti_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SEL_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic                     accept;
    action_t                  act;
    logic                     full;
    logic                     found;
    logic                     in_range;
    cell_cmd_t                cmd;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [VAL_W-1:0]  read_value_reg;
    logic signed [VAL_W-1:0]  read_value_next;
    logic [4:0]               entry_count_reg;
    logic [4:0]               entry_count_next;
    logic [CNT_W+4:0]         count_wide;

    logic signed [VAL_W-1:0]  entries [CAPACITY];
    logic [CAPACITY-1:0]      ge;
    logic [CAPACITY-1:0]      hit;
    logic [CAPACITY-1:0]      occ;
    logic [CAPACITY-1:0]      rd_hit;
    logic [VAL_W-1:0]         rd_chain [CAPACITY];

    // Handshake: take an item whenever the output register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign act      = action_t'(action);

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = hit[CAPACITY-1];
    assign in_range = (CMP_W'(position) < CMP_W'(count_reg));

    // Command broadcast to the cells.
    always_comb
    begin
        cmd.ins   = accept && (act == ACT_INSERT) && !full;
        cmd.del   = accept && (act == ACT_DELETE);
        cmd.value = value;
    end

    // Chain of cells with neighbor links.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_entry;
        logic                    left_ge;
        logic signed [VAL_W-1:0] right_entry;
        logic                    hit_in;
        logic [VAL_W-1:0]        rd_in;

        assign occ[i]    = (CNT_W'(i) < count_reg);
        assign rd_hit[i] = (SEL_W'(i) == SEL_W'(position));

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_ge    = 1'b0;
            assign hit_in     = 1'b0;
            assign rd_in      = '0;
        end
        else
        begin : g_mid
            assign left_entry = entries[i-1];
            assign left_ge    = ge[i-1];
            assign hit_in     = hit[i-1];
            assign rd_in      = rd_chain[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = entries[i+1];
        end

        sti_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (occ[i]),
            .left_entry  (left_entry),
            .left_ge     (left_ge),
            .right_entry (right_entry),
            .hit_in      (hit_in),
            .read_here   (rd_hit[i]),
            .rd_in       (rd_in),
            .entry       (entries[i]),
            .ge          (ge[i]),
            .hit_out     (hit[i]),
            .rd_out      (rd_chain[i])
        );
    end

    // Next count.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.del && found)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_wide = (CNT_W + 5)'(count_next);

    // Result of the accepted item.
    always_comb
    begin
        status_next      = ST_OK;
        read_value_next  = '0;
        entry_count_next = count_wide[4:0];
        case (act)
            ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
            end
            ACT_DELETE:
            begin
                if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            ACT_READ:
            begin
                if (in_range)
                begin
                    read_value_next = rd_chain[CAPACITY-1];
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Output valid tracking.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

    // Checks on the count, the output register and the cell command.
    `STI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `STI_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `STI_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.ins, count_reg == $past(count_reg) + 1'b1)
    `STI_ASSERT_IMP(a_full_count, clk, rst_n, out_valid_reg && (status_reg == ST_FULL), full)
    `STI_ASSERT_IMP(a_no_shift_both, clk, rst_n, cmd.ins, !cmd.del)

endmodule

`default_nettype wire
